/* sv/loser_tree_merge_select_core_assert.svh */
// Assertion macros shared by the checker of the loser tree merge select block.
// Each macro takes a label, the clock, the reset, the two sides and a message.
`ifndef LOSER_TREE_MERGE_SELECT_CORE_ASSERT_SVH
`define LOSER_TREE_MERGE_SELECT_CORE_ASSERT_SVH

// Same-cycle implication.
`define LTMS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LTMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ltms_pkg.sv */
// Package of the loser tree merge select block: request and response types,
// sequencer states and shared constants. Depends on nothing.
package ltms_pkg;

   localparam int MAX_SOURCES_DEF = 16;
   localparam int KEY_BITS_DEF    = 32;
   localparam int KEY_W           = 32;
   localparam int SRC_W           = 4;
   localparam int NSRC_W          = 5;

   localparam logic [NSRC_W-1:0] NUM_SOURCES_RST = 5'd16;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_REPLACE = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [SRC_W-1:0] source;
      logic [KEY_W-1:0] key;
      logic             exhausted;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [SRC_W-1:0] winner_source;
      logic [KEY_W-1:0] winner_key;
      logic             all_exhausted;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAF_RD,
      ST_LEAF_LD,
      ST_KEY_RD,
      ST_CMP,
      ST_FIN_RD,
      ST_FIN_OUT
   } state_type;

endpackage

/* sv/ltms_compare.sv */
// Shared compare unit of the loser tree: decides whether the entry parked at
// a node stays ahead of the climbing entry. Depends on nothing.
module ltms_compare #(
   parameter int KEY_BITS = 32
) (
   input  logic [KEY_BITS-1:0] parked_key,
   input  logic                parked_done,
   input  logic [KEY_BITS-1:0] climber_key,
   input  logic                climber_done,
   output logic                parked_wins
);

   // An exhausted source always loses, and a tie lets the climber move on.
   assign parked_wins = !parked_done && (climber_done || (parked_key < climber_key));

endmodule

/* sv/loser_tree_merge_select_core.sv */
// Top level of the loser tree merge select block: sequencer, node and key
// memories. Depends on ltms_pkg and ltms_compare.
//
// A load request without last gives no response. A load with last rebuilds
// the tree: every leaf climbs to the first empty node. A replace request
// replays the winner from its leaf to the root. The pace is set by the single
// compare unit and the one read port of each of the node and key memories.
// Busy is high while the tree is worked; each response is shown for exactly
// one cycle, and a new request may be taken in that same cycle.
module loser_tree_merge_select_core #(
   parameter int MAX_SOURCES = ltms_pkg::MAX_SOURCES_DEF,
   parameter int KEY_BITS    = ltms_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ltms_pkg::req_type           req_item,
   output logic                        rsp_strobe,
   output ltms_pkg::rsp_type           rsp_item,
   input  logic                        csr_we,
   input  logic [ltms_pkg::NSRC_W-1:0] csr_wdata
);
   import ltms_pkg::*;

   localparam int ENT_W   = $clog2(MAX_SOURCES);
   localparam int LEAF_W  = ENT_W + 1;
   localparam int STORE_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

   state_type state_ff, state_in;

   logic [NSRC_W-1:0]      num_sources_ff, num_sources_in;
   logic [ENT_W-1:0]       win_ff, win_in;
   logic [ENT_W-1:0]       cidx_ff, cidx_in;
   logic [STORE_W-1:0]     ck_ff, ck_in;
   logic                   cd_ff, cd_in;
   logic [ENT_W-1:0]       p_ff, p_in;
   logic [ENT_W-1:0]       lf_ff, lf_in;
   logic                   build_ff, build_in;
   logic [MAX_SOURCES-1:0] node_valid_ff, node_valid_in;
   logic [MAX_SOURCES-1:0] head_done_ff, head_done_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic [ENT_W-1:0]   node_mem [MAX_SOURCES];
   logic [ENT_W-1:0]   node_rd_ff;
   logic               node_we;
   logic [ENT_W-1:0]   node_waddr;
   logic [ENT_W-1:0]   node_raddr;

   logic [STORE_W-1:0] key_mem [MAX_SOURCES];
   logic [STORE_W-1:0] key_rd_ff;
   logic               key_we;
   logic [ENT_W-1:0]   key_waddr;
   logic [ENT_W-1:0]   key_raddr;
   logic [STORE_W-1:0] key_wdata;

   logic [LEAF_W-1:0]      n_act;
   logic [MAX_SOURCES-1:0] active;
   logic                   src_ok;
   logic [ENT_W-1:0]       src_idx;
   logic [ENT_W-1:0]       rep_w;
   logic [LEAF_W-1:0]      rep_leaf;
   logic [LEAF_W-1:0]      build_leaf;
   logic                   parked_done;
   logic                   parked_wins;

   always_comb begin
      if (num_sources_ff == '0) begin
         n_act = LEAF_W'(1);
      end else if (int'(num_sources_ff) > MAX_SOURCES) begin
         n_act = LEAF_W'(MAX_SOURCES);
      end else begin
         n_act = LEAF_W'(num_sources_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
         active[i] = (LEAF_W'(i) < n_act);
      end
   end

   assign src_ok     = (int'(req_item.source) < MAX_SOURCES);
   assign src_idx    = ENT_W'(req_item.source);
   assign rep_w      = (LEAF_W'(win_ff) >= n_act) ? '0 : win_ff;
   assign rep_leaf   = LEAF_W'(rep_w) + n_act;
   assign build_leaf = LEAF_W'(lf_ff) + n_act;
   assign key_wdata  = STORE_W'(req_item.key);
   assign parked_done = head_done_ff[node_rd_ff];

   ltms_compare #(
      .KEY_BITS (STORE_W)
   ) u_compare (
      .parked_key   (key_rd_ff),
      .parked_done  (parked_done),
      .climber_key  (ck_ff),
      .climber_done (cd_ff),
      .parked_wins  (parked_wins)
   );

   always_comb begin
      state_in       = state_ff;
      num_sources_in = num_sources_ff;
      win_in         = win_ff;
      cidx_in        = cidx_ff;
      ck_in          = ck_ff;
      cd_in          = cd_ff;
      p_in           = p_ff;
      lf_in          = lf_ff;
      build_in       = build_ff;
      node_valid_in  = node_valid_ff;
      head_done_in   = head_done_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      node_we        = 1'b0;
      node_waddr     = p_ff;
      node_raddr     = p_ff;
      key_we         = 1'b0;
      key_waddr      = src_idx;
      key_raddr      = lf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.mode == MODE_LOAD) begin
                  if (src_ok) begin
                     key_we                = 1'b1;
                     head_done_in[src_idx] = req_item.exhausted;
                  end
                  if (req_item.last) begin
                     node_valid_in = '0;
                     lf_in         = ENT_W'(n_act - LEAF_W'(1));
                     build_in      = 1'b1;
                     state_in      = ST_LEAF_RD;
                  end
               end else begin
                  key_we              = 1'b1;
                  key_waddr           = rep_w;
                  head_done_in[rep_w] = req_item.exhausted;
                  cidx_in             = rep_w;
                  ck_in               = key_wdata;
                  cd_in               = req_item.exhausted;
                  p_in                = ENT_W'(rep_leaf >> 1);
                  node_raddr          = ENT_W'(rep_leaf >> 1);
                  build_in            = 1'b0;
                  state_in            = ST_KEY_RD;
               end
            end
         end
         ST_LEAF_RD: begin
            cidx_in  = lf_ff;
            cd_in    = head_done_ff[lf_ff];
            p_in     = ENT_W'(build_leaf >> 1);
            state_in = ST_LEAF_LD;
         end
         ST_LEAF_LD: begin
            ck_in    = key_rd_ff;
            state_in = ST_KEY_RD;
         end
         ST_KEY_RD: begin
            if ((p_ff == '0) || !node_valid_ff[p_ff]) begin
               if (p_ff == '0) begin
                  win_in = cidx_ff;
               end else begin
                  node_we             = 1'b1;
                  node_valid_in[p_ff] = 1'b1;
               end
               if (build_ff && (lf_ff != '0)) begin
                  lf_in    = lf_ff - ENT_W'(1);
                  state_in = ST_LEAF_RD;
               end else begin
                  state_in = ST_FIN_RD;
               end
            end else begin
               key_raddr = node_rd_ff;
               state_in  = ST_CMP;
            end
         end
         ST_CMP: begin
            if (parked_wins) begin
               node_we = 1'b1;
               cidx_in = node_rd_ff;
               ck_in   = key_rd_ff;
               cd_in   = parked_done;
            end
            p_in       = p_ff >> 1;
            node_raddr = p_ff >> 1;
            state_in   = ST_KEY_RD;
         end
         ST_FIN_RD: begin
            key_raddr = win_ff;
            state_in  = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.winner_source = SRC_W'(win_ff);
            rsp_in.winner_key    = head_done_ff[win_ff] ? '0 : KEY_W'(key_rd_ff);
            rsp_in.all_exhausted = &(head_done_ff | ~active);
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         num_sources_in = csr_wdata;
         node_valid_in  = '0;
         win_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         num_sources_ff <= NUM_SOURCES_RST;
         win_ff         <= '0;
         node_valid_ff  <= '0;
         head_done_ff   <= '0;
         rsp_strobe_ff  <= 1'b0;
         build_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         num_sources_ff <= num_sources_in;
         win_ff         <= win_in;
         node_valid_ff  <= node_valid_in;
         head_done_ff   <= head_done_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         build_ff       <= build_in;
      end
   end

   always_ff @(posedge clock) begin
      cidx_ff <= cidx_in;
      ck_ff   <= ck_in;
      cd_ff   <= cd_in;
      p_ff    <= p_in;
      lf_ff   <= lf_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= cidx_ff;
      end
      node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* sv/ltms_checker.sv */
// Port-level checker of the loser tree merge select block and its binding.
// Depends on ltms_pkg and the assertion macro header.
`include "loser_tree_merge_select_core_assert.svh"

module ltms_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ltms_pkg::req_type req_item,
   input logic              rsp_strobe,
   input ltms_pkg::rsp_type rsp_item
);
   import ltms_pkg::*;

   logic req_acc;
   logic work_req;
   logic plain_req;
   logic idle_quiet;
   logic exh_rsp;
   logic key_zero;

   assign req_acc    = start && !busy;
   assign work_req   = req_acc && (req_item.mode == MODE_REPLACE || req_item.last);
   assign plain_req  = req_acc && (req_item.mode == MODE_LOAD) && !req_item.last;
   assign idle_quiet = !busy && !rsp_strobe;
   assign exh_rsp    = rsp_strobe && rsp_item.all_exhausted;
   assign key_zero   = (rsp_item.winner_key == '0);

   `LTMS_ASSERT_NEXT(a_work_busy, clock, reset, work_req, busy, "Work request left busy low.")
   `LTMS_ASSERT_NEXT(a_plain_load, clock, reset, plain_req, idle_quiet, "Load not idle.")
   `LTMS_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_strobe, !busy, "Response while busy.")
   `LTMS_ASSERT_IMPLY(a_exh_key, clock, reset, exh_rsp, key_zero, "Exhausted key not zero.")
   `LTMS_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_strobe, !rsp_strobe, "Strobe too long.")

endmodule

bind loser_tree_merge_select_core ltms_checker u_ltms_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
